### src/cal_add_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cal_add_pkg;

  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 7;
  localparam int unsigned IvalW  = 16;

  localparam int unsigned MinutesPerHour = 60;
  localparam int unsigned HoursPerDay    = 24;
  localparam int unsigned MonthsPerYear  = 12;

  // floor(x / 60) = floor(floor(x / 4) / 15); 1/15 ~ 17477 / 2^18, exact below 23834
  localparam int unsigned Recip15      = 17477;
  localparam int unsigned Recip15Shift = 18;
  // floor(x / 24) = floor(floor(x / 8) / 3); 1/3 ~ 171 / 2^9, exact below 512
  localparam int unsigned Recip3       = 171;
  localparam int unsigned Recip3Shift  = 9;

  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);

  typedef logic [DayW-1:0] mdays_t;

  localparam mdays_t MonthDays [MonthsPerYear] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // month must be 1..12; anything else is flagged and never uses the length
  function automatic mdays_t month_len(input logic [MonthW-1:0] month,
                                       input logic [YearW-1:0]  year);
    logic [MonthW-1:0] idx;
    mdays_t            len;
    idx = month - MonthW'(1);
    len = (idx < MonthW'(MonthsPerYear)) ? MonthDays[idx] : MonthDays[0];
    if (month == MonthFeb && year[1:0] == 2'b00) begin
      len = len + DayW'(1);
    end
    return len;
  endfunction

  function automatic logic month_bad(input logic [MonthW-1:0] month);
    return (month == MonthW'(0)) || (month > MonthW'(MonthsPerYear));
  endfunction

endpackage

`default_nettype wire

### src/calendar_add_minutes_top.sv
// Channel  | Handshake         | Fields
// ---------+-------------------+----------------------------------------------
// input    | start_i, busy_o   | cur_minute_i cur_hour_i cur_day_i cur_month_i
//          |                   | cur_year_i interval_minutes_i
// result   | done_o (strobe)   | next_minute_o next_hour_o next_day_o
//          |                   | next_month_o next_year_o bad_month_o
//
// Five register stages: minute add, reciprocal multiply for /60, minute
// remainder and hour add, /24 and day add, day/month/year carry.
// One item accepted every cycle; done_o is start_i carried through the stage valid bits.
// busy_o is held low: nothing in the pipe ever waits.
// Reset clears only the stage valid bits; the data registers carry no reset.
// The receiver cannot stall, so results leave on the strobe cycle and are gone.
`timescale 1ns / 1ps
`default_nettype none

module calendar_add_minutes_top
  import cal_add_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [MinW-1:0]   cur_minute_i,
  input  wire logic [HourW-1:0]  cur_hour_i,
  input  wire logic [DayW-1:0]   cur_day_i,
  input  wire logic [MonthW-1:0] cur_month_i,
  input  wire logic [YearW-1:0]  cur_year_i,
  input  wire logic [IvalW-1:0]  interval_minutes_i,
  output logic                   done_o,
  output logic [MinW-1:0]        next_minute_o,
  output logic [HourW-1:0]       next_hour_o,
  output logic [DayW-1:0]        next_day_o,
  output logic [MonthW-1:0]      next_month_o,
  output logic [YearW-1:0]       next_year_o,
  output logic                   bad_month_o
);

  localparam int unsigned SumW   = IvalW + 1;   // minute + interval
  localparam int unsigned Q1W    = 11;          // hour carry, up to 1093
  localparam int unsigned HsW    = 11;          // hour + carry, up to 1124
  localparam int unsigned Q2W    = 6;           // day carry, up to 46
  localparam int unsigned DsW    = 7;           // day + carry
  localparam int unsigned Prod1W = 30;
  localparam int unsigned Prod2W = 16;

  // the pipe never holds items back
  assign busy_o = 1'b0;

  // -------------------------------------------------------------------------
  // Stage valid bits
  // -------------------------------------------------------------------------
  logic [4:0] vld_q, vld_d;

  assign vld_d = {vld_q[3:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o = vld_q[4];

  // -------------------------------------------------------------------------
  // Stage 1: minute sum, month length, month check
  // -------------------------------------------------------------------------
  logic [SumW-1:0]   s1_sum_q, s1_sum_d;
  logic [MinW-1:0]   s1_min_q;
  logic [HourW-1:0]  s1_hour_q;
  logic [DayW-1:0]   s1_day_q;
  logic [MonthW-1:0] s1_month_q;
  logic [YearW-1:0]  s1_year_q;
  mdays_t            s1_mdays_q, s1_mdays_d;
  logic              s1_bad_q, s1_bad_d;

  always_comb begin
    s1_sum_d   = SumW'(cur_minute_i) + SumW'(interval_minutes_i);
    s1_mdays_d = month_len(cur_month_i, cur_year_i);
    s1_bad_d   = month_bad(cur_month_i);
  end

  always_ff @(posedge clk_i) begin
    s1_sum_q   <= s1_sum_d;
    s1_min_q   <= cur_minute_i;
    s1_hour_q  <= cur_hour_i;
    s1_day_q   <= cur_day_i;
    s1_month_q <= cur_month_i;
    s1_year_q  <= cur_year_i;
    s1_mdays_q <= s1_mdays_d;
    s1_bad_q   <= s1_bad_d;
  end

  // -------------------------------------------------------------------------
  // Stage 2: hour carry = sum / 60 by reciprocal multiply
  // -------------------------------------------------------------------------
  logic [Prod1W-1:0] s2_prod;
  logic [Q1W-1:0]    s2_q1_q, s2_q1_d;
  logic [SumW-1:0]   s2_sum_q;
  logic [MinW-1:0]   s2_min_q;
  logic [HourW-1:0]  s2_hour_q;
  logic [DayW-1:0]   s2_day_q;
  logic [MonthW-1:0] s2_month_q;
  logic [YearW-1:0]  s2_year_q;
  mdays_t            s2_mdays_q;
  logic              s2_bad_q;

  always_comb begin
    s2_prod = Prod1W'(s1_sum_q[SumW-1:2]) * Prod1W'(Recip15);
    s2_q1_d = s2_prod[Recip15Shift +: Q1W];
  end

  always_ff @(posedge clk_i) begin
    s2_q1_q    <= s2_q1_d;
    s2_sum_q   <= s1_sum_q;
    s2_min_q   <= s1_min_q;
    s2_hour_q  <= s1_hour_q;
    s2_day_q   <= s1_day_q;
    s2_month_q <= s1_month_q;
    s2_year_q  <= s1_year_q;
    s2_mdays_q <= s1_mdays_q;
    s2_bad_q   <= s1_bad_q;
  end

  // -------------------------------------------------------------------------
  // Stage 3: minute remainder, hour sum
  // -------------------------------------------------------------------------
  logic [SumW-1:0]   s3_rem;
  logic [MinW-1:0]   s3_min_q, s3_min_d;
  logic [HsW-1:0]    s3_hs_q, s3_hs_d;
  logic              s3_c1_q, s3_c1_d;
  logic [HourW-1:0]  s3_hour_q;
  logic [DayW-1:0]   s3_day_q;
  logic [MonthW-1:0] s3_month_q;
  logic [YearW-1:0]  s3_year_q;
  mdays_t            s3_mdays_q;
  logic              s3_bad_q;

  always_comb begin
    // q1 * 60 = q1 * 64 - q1 * 4
    s3_rem   = s2_sum_q - ((SumW'(s2_q1_q) << 6) - (SumW'(s2_q1_q) << 2));
    s3_min_d = s2_bad_q ? s2_min_q : s3_rem[MinW-1:0];
    s3_hs_d  = HsW'(s2_hour_q) + HsW'(s2_q1_q);
    s3_c1_d  = !s2_bad_q && (s2_q1_q != '0);
  end

  always_ff @(posedge clk_i) begin
    s3_min_q   <= s3_min_d;
    s3_hs_q    <= s3_hs_d;
    s3_c1_q    <= s3_c1_d;
    s3_hour_q  <= s2_hour_q;
    s3_day_q   <= s2_day_q;
    s3_month_q <= s2_month_q;
    s3_year_q  <= s2_year_q;
    s3_mdays_q <= s2_mdays_q;
    s3_bad_q   <= s2_bad_q;
  end

  // -------------------------------------------------------------------------
  // Stage 4: hour / 24, day sum
  // -------------------------------------------------------------------------
  logic [Prod2W-1:0] s4_prod;
  logic [Q2W-1:0]    s4_q2;
  logic [HsW-1:0]    s4_rem;
  logic [MinW-1:0]   s4_min_q;
  logic [HourW-1:0]  s4_hour_q, s4_hour_d;
  logic [DsW-1:0]    s4_dm1_q, s4_dm1_d;   // day + carry - 1
  logic              s4_c2_q, s4_c2_d;
  logic [DayW-1:0]   s4_day_q;
  logic [MonthW-1:0] s4_month_q;
  logic [YearW-1:0]  s4_year_q;
  mdays_t            s4_mdays_q;
  logic              s4_bad_q;

  always_comb begin
    s4_prod   = Prod2W'(s3_hs_q[HsW-1:3]) * Prod2W'(Recip3);
    s4_q2     = s4_prod[Recip3Shift +: Q2W];
    // q2 * 24 = q2 * 16 + q2 * 8
    s4_rem    = s3_hs_q - ((HsW'(s4_q2) << 4) + (HsW'(s4_q2) << 3));
    s4_hour_d = s3_c1_q ? s4_rem[HourW-1:0] : s3_hour_q;
    s4_c2_d   = s3_c1_q && (s4_q2 != '0);
    s4_dm1_d  = DsW'(s3_day_q) + DsW'(s4_q2) - DsW'(1);
  end

  always_ff @(posedge clk_i) begin
    s4_min_q   <= s3_min_q;
    s4_hour_q  <= s4_hour_d;
    s4_dm1_q   <= s4_dm1_d;
    s4_c2_q    <= s4_c2_d;
    s4_day_q   <= s3_day_q;
    s4_month_q <= s3_month_q;
    s4_year_q  <= s3_year_q;
    s4_mdays_q <= s3_mdays_q;
    s4_bad_q   <= s3_bad_q;
  end

  // -------------------------------------------------------------------------
  // Stage 5: day wrap against the start month's length, month and year carry.
  // Day carry is at most two months, so two compares settle it.
  // -------------------------------------------------------------------------
  logic [DsW-1:0]    s5_m1, s5_m2, s5_dwrap;
  logic [1:0]        s5_c3;
  logic [MonthW-1:0] s5_msum;
  logic [DayW-1:0]   s5_day_d;
  logic [MonthW-1:0] s5_month_d;
  logic [YearW-1:0]  s5_year_d;
  logic [MinW-1:0]   out_min_q;
  logic [HourW-1:0]  out_hour_q;
  logic [DayW-1:0]   out_day_q;
  logic [MonthW-1:0] out_month_q;
  logic [YearW-1:0]  out_year_q;
  logic              out_bad_q;

  always_comb begin
    s5_m1      = DsW'(s4_mdays_q);
    s5_m2      = DsW'(s4_mdays_q) << 1;
    if (s4_dm1_q >= s5_m2) begin
      s5_c3    = 2'd2;
      s5_dwrap = s4_dm1_q - s5_m2;
    end else if (s4_dm1_q >= s5_m1) begin
      s5_c3    = 2'd1;
      s5_dwrap = s4_dm1_q - s5_m1;
    end else begin
      s5_c3    = 2'd0;
      s5_dwrap = s4_dm1_q;
    end
    s5_msum    = s4_month_q + MonthW'(s5_c3);
    s5_day_d   = s4_day_q;
    s5_month_d = s4_month_q;
    s5_year_d  = s4_year_q;
    if (s4_c2_q) begin
      s5_day_d = s5_dwrap[DayW-1:0] + DayW'(1);
      if (s5_c3 != 2'd0) begin
        if (s5_msum > MonthW'(MonthsPerYear)) begin
          s5_month_d = s5_msum - MonthW'(MonthsPerYear);
          s5_year_d  = s4_year_q + YearW'(1);
        end else begin
          s5_month_d = s5_msum;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_min_q   <= s4_min_q;
    out_hour_q  <= s4_hour_q;
    out_day_q   <= s5_day_d;
    out_month_q <= s5_month_d;
    out_year_q  <= s5_year_d;
    out_bad_q   <= s4_bad_q;
  end

  assign next_minute_o = out_min_q;
  assign next_hour_o   = out_hour_q;
  assign next_day_o    = out_day_q;
  assign next_month_o  = out_month_q;
  assign next_year_o   = out_year_q;
  assign bad_month_o   = out_bad_q;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##5 done_o)
    else $error("item lost in pipe");

  a_minute_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !bad_month_o |-> next_minute_o < MinW'(MinutesPerHour))
    else $error("minute remainder out of range");

  a_month_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !bad_month_o |-> next_month_o != '0 && next_month_o <= MonthW'(MonthsPerYear))
    else $error("month out of range");

  a_bad_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##5 bad_month_o == month_bad($past(cur_month_i, 5)))
    else $error("bad month flag mismatch");
`endif

endmodule

`default_nettype wire

### test/calendar_add_minutes_top_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for calendar_add_minutes_top.
// Items go in through the start/busy handshake. Each accepted item queues its
// predicted alarm time. The result strobe pops the oldest prediction and is
// checked field by field. The sender idles at random in three phases: light
// idling, heavy idling, then none. A watchdog ends the run if nothing moves.
module calendar_add_minutes_top_tb
  import cal_add_pkg::*;
;

  localparam int unsigned LeapPeriod = 4;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned ItemsPerPhase = 450;

  // month lengths held by the bench, independent of the block's own table
  localparam int unsigned DaysInMonth [MonthsPerYear] = '{
    31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  typedef struct packed {
    logic [MinW-1:0]   minute;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [IvalW-1:0]  interval;
  } cal_time_t;

  typedef struct packed {
    logic [MinW-1:0]   minute;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic              bad;
  } alarm_time_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [MinW-1:0]   cur_minute_i = '0;
  logic [HourW-1:0]  cur_hour_i = '0;
  logic [DayW-1:0]   cur_day_i = '0;
  logic [MonthW-1:0] cur_month_i = '0;
  logic [YearW-1:0]  cur_year_i = '0;
  logic [IvalW-1:0]  interval_minutes_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [MinW-1:0]   next_minute_o;
  logic [HourW-1:0]  next_hour_o;
  logic [DayW-1:0]   next_day_o;
  logic [MonthW-1:0] next_month_o;
  logic [YearW-1:0]  next_year_o;
  logic              bad_month_o;

  alarm_time_t pending_alarms [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;

  calendar_add_minutes_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .cur_minute_i       (cur_minute_i),
    .cur_hour_i         (cur_hour_i),
    .cur_day_i          (cur_day_i),
    .cur_month_i        (cur_month_i),
    .cur_year_i         (cur_year_i),
    .interval_minutes_i (interval_minutes_i),
    .done_o             (done_o),
    .next_minute_o      (next_minute_o),
    .next_hour_o        (next_hour_o),
    .next_day_o         (next_day_o),
    .next_month_o       (next_month_o),
    .next_year_o        (next_year_o),
    .bad_month_o        (bad_month_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Alarm time prediction. Carrying goes stage by stage and stops at the first
  // stage that does not overflow. The day carry always uses the length of the
  // incoming month, even when it spans several months.
  function automatic alarm_time_t predict_alarm(input cal_time_t t);
    int unsigned mn, hr, dy, mo, yr, carry, mlen;
    alarm_time_t r;
    mn = t.minute;
    hr = t.hour;
    dy = t.day;
    mo = t.month;
    yr = t.year;
    r.bad = (mo == 0) || (mo > MonthsPerYear);
    if (!r.bad) begin
      mn = mn + t.interval;
      carry = mn / MinutesPerHour;
      mn = mn % MinutesPerHour;
      if (carry != 0) begin
        hr = hr + carry;
        carry = hr / HoursPerDay;
        if (carry != 0) begin
          hr = hr % HoursPerDay;
          dy = dy + carry;
          mlen = DaysInMonth[mo - 1];
          if (mo == MonthFeb && (yr % LeapPeriod) == 0) begin
            mlen = mlen + 1;
          end
          carry = (dy - 1) / mlen;
          if (carry != 0) begin
            dy = (dy - 1) % mlen + 1;
            mo = mo + carry;
            carry = (mo - 1) / MonthsPerYear;
            if (carry != 0) begin
              mo = (mo - 1) % MonthsPerYear + 1;
              yr = yr + carry;  // 7-bit field, wraps past 127
            end
          end
        end
      end
    end
    r.minute = MinW'(mn);
    r.hour   = HourW'(hr);
    r.day    = DayW'(dy);
    r.month  = MonthW'(mo);
    r.year   = YearW'(yr);
    return r;
  endfunction

  function automatic cal_time_t cal_time(input int unsigned mn, input int unsigned hr,
                                         input int unsigned dy, input int unsigned mo,
                                         input int unsigned yr, input int unsigned iv);
    cal_time_t t;
    t.minute   = MinW'(mn);
    t.hour     = HourW'(hr);
    t.day      = DayW'(dy);
    t.month    = MonthW'(mo);
    t.year     = YearW'(yr);
    t.interval = IvalW'(iv);
    return t;
  endfunction

  // Called and returning on a falling edge. start_i is only lowered for an
  // idle gap, so back-to-back items keep it high without a glitch.
  task automatic send_time(input cal_time_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i            <= 1'b1;
    cur_minute_i       <= t.minute;
    cur_hour_i         <= t.hour;
    cur_day_i          <= t.day;
    cur_month_i        <= t.month;
    cur_year_i         <= t.year;
    interval_minutes_i <= t.interval;
    do begin
      @(posedge clk_i);
    end while (busy_o !== 1'b0);
    pending_alarms.push_back(predict_alarm(t));
    @(negedge clk_i);
  endtask

  task automatic test_field_extremes();
    send_time(cal_time(0, 0, 1, 1, 0, 0));
    send_time(cal_time(59, 23, 31, 12, 99, 65535));
    // every input bit high with a valid month: year runs past 127 and wraps
    send_time(cal_time(63, 31, 31, 12, 127, 65535));
    send_time(cal_time(63, 31, 31, 12, 127, 0));
  endtask

  task automatic test_bad_month();
    send_time(cal_time(59, 23, 31, 0, 99, 65535));
    send_time(cal_time(30, 12, 15, 13, 20, 1000));
    send_time(cal_time(63, 31, 0, 15, 127, 1));
  endtask

  task automatic test_leap_february();
    send_time(cal_time(59, 23, 28, 2, 4, 1));    // leap: lands on the 29th
    send_time(cal_time(59, 23, 28, 2, 5, 1));    // common year: 1st March
    send_time(cal_time(59, 23, 29, 2, 0, 1));
    send_time(cal_time(0, 0, 28, 2, 100, 1440)); // out-of-range year, still leap
  endtask

  task automatic test_carry_chain();
    send_time(cal_time(10, 5, 10, 6, 21, 5));       // minutes only
    send_time(cal_time(59, 5, 10, 6, 21, 1));       // into hours
    send_time(cal_time(0, 23, 10, 6, 21, 60));      // into days
    send_time(cal_time(59, 23, 31, 12, 99, 1));     // all the way into the year
    send_time(cal_time(0, 0, 31, 1, 30, 65535));    // spans months with January's length
    send_time(cal_time(0, 0, 0, 5, 30, 30));        // day 0, no day carry
    send_time(cal_time(0, 0, 31, 4, 30, 600));      // day 31 in April, no day carry
    send_time(cal_time(0, 23, 0, 9, 30, 60));       // day 0 with a day carry
    send_time(cal_time(45, 20, 30, 11, 50, 64000)); // several months and a year
  endtask

  // Mostly valid times with random content; a share uses the full field
  // widths so every bit and every out-of-range value turns up.
  task automatic test_random_times(input int unsigned count);
    cal_time_t t;
    int unsigned pick;
    repeat (count) begin
      t.month  = ($urandom_range(9) != 0) ? MonthW'($urandom_range(MonthsPerYear, 1))
                                          : MonthW'($urandom_range(15));
      t.minute = ($urandom_range(6) != 0) ? MinW'($urandom_range(59)) : MinW'($urandom);
      t.hour   = ($urandom_range(6) != 0) ? HourW'($urandom_range(23)) : HourW'($urandom);
      pick = $urandom_range(99);
      if (pick < 40) begin
        t.day = DayW'($urandom_range(31, 25));
      end else if (pick < 85) begin
        t.day = DayW'($urandom_range(31, 1));
      end else begin
        t.day = DayW'($urandom);
      end
      t.year = ($urandom_range(6) != 0) ? YearW'($urandom_range(99)) : YearW'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) begin
        t.interval = IvalW'($urandom_range(119));
      end else if (pick < 60) begin
        t.interval = IvalW'($urandom_range(2880));
      end else begin
        t.interval = IvalW'($urandom);
      end
      send_time(t);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // results cannot be held off, so each strobe is checked on its own edge
  always @(posedge clk_i) begin : check_alarm
    alarm_time_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_alarms.size() == 0) begin
        mismatches++;
        $display("%0t: result with no item outstanding, expected none actual %0d:%0d",
                 $time, next_hour_o, next_minute_o);
      end else begin
        want = pending_alarms.pop_front();
        check_field("next_minute", want.minute, next_minute_o);
        check_field("next_hour", want.hour, next_hour_o);
        check_field("next_day", want.day, next_day_o);
        check_field("next_month", want.month, next_month_o);
        check_field("next_year", want.year, next_year_o);
        check_field("bad_month", want.bad, bad_month_o);
      end
    end
  end

  // a cycle counts as quiet when no item goes in and no result comes out
  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("calendar_add_minutes_top_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 20;
    test_field_extremes();
    test_bad_month();
    test_leap_february();
    test_carry_chain();
    test_random_times(ItemsPerPhase);

    send_idle_pct = 81;
    test_random_times(ItemsPerPhase);

    send_idle_pct = 0;
    test_random_times(ItemsPerPhase);

    start_i <= 1'b0;
    while (pending_alarms.size() != 0) begin
      @(posedge clk_i);
    end
    // a few more cycles to catch any stray strobe
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("calendar_add_minutes_top_tb OK");
    end else begin
      $display("calendar_add_minutes_top_tb NOT OK");
    end
    $finish;
  end

endmodule
